@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the LIF neuron block.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-gated
`define LNDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-gated
`define LNDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lnds_pkg.sv @@
// Shared types, widths and helpers for the LIF neuron block.
// No dependencies; used by every module of the block.
`default_nettype none

package lnds_pkg;

  // Field and datapath widths
  localparam int VAL_W   = 24;                 // potentials and currents, 16.8
  localparam int CUR_W   = 24;
  localparam int DEC_W   = 16;                 // decay, 0.16
  localparam int GAIN_W  = 20;                 // gain, 4.16
  localparam int REFR_W  = 8;                  // refractory counter
  localparam int FRAC_W  = 16;                 // factor fraction bits
  localparam int PW_W    = FRAC_W + 1;         // power value, up to 1.0
  localparam int HB_W    = CUR_W + 1;          // held + bias
  localparam int MA_W    = HB_W + 1;           // multiplier operand A, signed
  localparam int MB_W    = GAIN_W + 1;         // multiplier operand B, signed
  localparam int PROD_W  = MA_W + MB_W;
  localparam int RND_W   = PROD_W - FRAC_W;
  localparam int ACC_W   = RND_W + 1;          // tick sum accumulator
  localparam int PC_W    = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  localparam logic [PW_W-1:0]   PW_ONE   = PW_W'(1) << FRAC_W;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (VAL_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  // Microcode fields
  typedef enum logic [2:0] {
    MUL_NONE, MUL_MEM_DECAY, MUL_HB_GAIN, MUL_RES_BASE, MUL_BASE_BASE, MUL_SPIKE_RES
  } mul_op_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LOAD_IN, ACC_ADD_RACC, ACC_ADD_PROD
  } acc_op_e;

  typedef enum logic [2:0] {
    WB_NONE, WB_MEMBRANE, WB_PW_INIT, WB_RES_COND, WB_BASE_SHIFT, WB_RACC, WB_DEC, WB_FIRE
  } wb_op_e;

  typedef enum logic [2:0] {
    J_NEXT, J_ALWAYS, J_REFR, J_NOHOLD, J_NMORE
  } jmp_e;

  typedef struct packed {
    mul_op_e         mul;
    acc_op_e         acc;
    wb_op_e          wb;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            last;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic refr;    // refractory count nonzero
    logic hold;    // hold mode on
    logic nmore;   // power exponent has bits left after this one
  } flags_t;

  // Configuration registers
  typedef struct packed {
    logic [DEC_W-1:0]  decay;
    logic [GAIN_W-1:0] gain;
    logic [CUR_W-1:0]  bias;
    logic [VAL_W-1:0]  threshold;
    logic [VAL_W-1:0]  reset_level;
    logic [VAL_W-1:0]  floor_level;
    logic [REFR_W-1:0] refr_steps;
    logic              hold;
  } cfg_t;

  // Saturate an accumulator value to the potential range
  function automatic logic [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] x);
    logic [VAL_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[VAL_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[VAL_W-1:0];
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lnds_cfg.sv @@
// APB-style configuration register file of the LIF neuron block.
// Depends on lnds_pkg (cfg_t, widths).
`default_nettype none

module lnds_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lnds_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lnds_pkg::DATA_W-1:0]  pwdata,
  output logic      [lnds_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output lnds_pkg::cfg_t                    cfg_o
);
  import lnds_pkg::*;

  typedef enum logic [2:0] {
    REG_DECAY, REG_GAIN, REG_BIAS, REG_THRESH, REG_RESET, REG_FLOOR, REG_REFR, REG_HOLD
  } reg_idx_e;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay       <= DEC_W'(59299);
      cfg_q.gain        <= GAIN_W'(249);
      cfg_q.bias        <= '0;
      cfg_q.threshold   <= VAL_W'(3840);
      cfg_q.reset_level <= '0;
      cfg_q.floor_level <= SAT_LO[VAL_W-1:0];
      cfg_q.refr_steps  <= REFR_W'(20);
      cfg_q.hold        <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DECAY:  cfg_q.decay       <= pwdata[DEC_W-1:0];
        REG_GAIN:   cfg_q.gain        <= pwdata[GAIN_W-1:0];
        REG_BIAS:   cfg_q.bias        <= pwdata[CUR_W-1:0];
        REG_THRESH: cfg_q.threshold   <= pwdata[VAL_W-1:0];
        REG_RESET:  cfg_q.reset_level <= pwdata[VAL_W-1:0];
        REG_FLOOR:  cfg_q.floor_level <= pwdata[VAL_W-1:0];
        REG_REFR:   cfg_q.refr_steps  <= pwdata[REFR_W-1:0];
        REG_HOLD:   cfg_q.hold        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back, signed registers sign-extended
  always_comb begin
    unique case (idx)
      REG_DECAY:  prdata = {{(DATA_W-DEC_W){1'b0}}, cfg_q.decay};
      REG_GAIN:   prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_q.gain};
      REG_BIAS:   prdata = {{(DATA_W-CUR_W){cfg_q.bias[CUR_W-1]}}, cfg_q.bias};
      REG_THRESH: prdata = {{(DATA_W-VAL_W){cfg_q.threshold[VAL_W-1]}}, cfg_q.threshold};
      REG_RESET:  prdata = {{(DATA_W-VAL_W){cfg_q.reset_level[VAL_W-1]}}, cfg_q.reset_level};
      REG_FLOOR:  prdata = {{(DATA_W-VAL_W){cfg_q.floor_level[VAL_W-1]}}, cfg_q.floor_level};
      REG_REFR:   prdata = {{(DATA_W-REFR_W){1'b0}}, cfg_q.refr_steps};
      REG_HOLD:   prdata = {{(DATA_W-1){1'b0}}, cfg_q.hold};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/lnds_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on lnds_pkg (ctrl_t, flags_t) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lnds_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire lnds_pkg::flags_t  flags_i,
  input  wire logic              out_free_i,
  output lnds_pkg::ctrl_t        ctrl_o,
  output logic                   busy_o
);
  import lnds_pkg::*;

  // Program addresses
  localparam logic [PC_W-1:0] PC_DISP    = PC_W'(0);
  localparam logic [PC_W-1:0] PC_MDECAY  = PC_W'(1);
  localparam logic [PC_W-1:0] PC_MGAIN   = PC_W'(2);
  localparam logic [PC_W-1:0] PC_ADDG    = PC_W'(3);
  localparam logic [PC_W-1:0] PC_MEMWB   = PC_W'(4);
  localparam logic [PC_W-1:0] PC_PWINIT  = PC_W'(5);
  localparam logic [PC_W-1:0] PC_PWMUL   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_PWRES   = PC_W'(7);
  localparam logic [PC_W-1:0] PC_PWBASE  = PC_W'(8);
  localparam logic [PC_W-1:0] PC_SPKMUL  = PC_W'(9);
  localparam logic [PC_W-1:0] PC_SPKACC  = PC_W'(10);
  localparam logic [PC_W-1:0] PC_DEC     = PC_W'(11);
  localparam logic [PC_W-1:0] PC_FIRE    = PC_W'(12);

  localparam ctrl_t CTRL_NOP = '{mul: MUL_NONE, acc: ACC_NONE, wb: WB_NONE,
                                 jmp: J_NEXT, target: PC_DISP, last: 1'b0};

  // Control ROM
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      // load spike into accumulator, form held + bias; refractory ticks branch off
      PC_DISP: begin
        w.acc = ACC_LOAD_IN; w.jmp = J_REFR; w.target = PC_PWINIT;
      end
      PC_MDECAY: begin
        w.mul = MUL_MEM_DECAY; w.acc = ACC_ADD_RACC;
      end
      PC_MGAIN: begin
        w.mul = MUL_HB_GAIN; w.acc = ACC_ADD_PROD;
      end
      PC_ADDG: begin
        w.acc = ACC_ADD_PROD;
      end
      PC_MEMWB: begin
        w.wb = WB_MEMBRANE; w.jmp = J_ALWAYS; w.target = PC_FIRE;
      end
      // refractory: decay^count by repeated squaring
      PC_PWINIT: begin
        w.wb = WB_PW_INIT; w.jmp = J_NOHOLD; w.target = PC_DEC;
      end
      PC_PWMUL: begin
        w.mul = MUL_RES_BASE;
      end
      PC_PWRES: begin
        w.wb = WB_RES_COND; w.mul = MUL_BASE_BASE;
      end
      PC_PWBASE: begin
        w.wb = WB_BASE_SHIFT; w.jmp = J_NMORE; w.target = PC_PWMUL;
      end
      PC_SPKMUL: begin
        w.mul = MUL_SPIKE_RES;
      end
      PC_SPKACC: begin
        w.wb = WB_RACC;
      end
      PC_DEC: begin
        w.wb = WB_DEC;
      end
      PC_FIRE: begin
        w.wb = WB_FIRE; w.last = 1'b1;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            stall;
  logic            take;

  // Decode current step and jump condition
  always_comb begin
    word  = ucode(pc_q);
    stall = word.last && !out_free_i;
    unique case (word.jmp)
      J_NEXT:   take = 1'b0;
      J_ALWAYS: take = 1'b1;
      J_REFR:   take = flags_i.refr;
      J_NOHOLD: take = !flags_i.hold;
      J_NMORE:  take = flags_i.nmore;
      default:  take = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      busy_d = start_i;
      pc_d   = PC_DISP;
    end else if (stall) begin
      pc_d = pc_q;
    end else if (word.last) begin
      busy_d = 1'b0;
      pc_d   = PC_DISP;
    end else begin
      pc_d = take ? word.target : pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_DISP;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign ctrl_o = (busy_q && !stall) ? word : CTRL_NOP;
  assign busy_o = busy_q;

  `LNDS_ASSERT_NXT(a_start_at_disp, clk_i, rst_ni, !busy_q && start_i, busy_q && pc_q == PC_DISP, "item did not start at dispatch step")
  `LNDS_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, busy_q && word.last && !out_free_i, busy_q && pc_q == $past(pc_q), "final step left while result pending")
  `LNDS_ASSERT_NXT(a_last_ends, clk_i, rst_ni, busy_q && word.last && out_free_i, !busy_q, "sequencer still busy after final step")

endmodule

`default_nettype wire

@@ hw/rtl/lnds_dp.sv @@
// Datapath of the LIF neuron: shared multiplier, accumulator, neuron state.
// Depends on lnds_pkg (ctrl_t, flags_t, cfg_t, sat_val).
`default_nettype none

module lnds_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lnds_pkg::cfg_t               cfg_i,
  input  wire lnds_pkg::ctrl_t              ctrl_i,
  input  wire logic                         load_i,
  input  wire logic [lnds_pkg::VAL_W-1:0]   spike_i,
  input  wire logic [lnds_pkg::CUR_W-1:0]   current_i,
  output lnds_pkg::flags_t                  flags_o,
  output logic                              fire_o,
  output logic      [lnds_pkg::VAL_W-1:0]   potential_o
);
  import lnds_pkg::*;

  // Neuron state
  logic [VAL_W-1:0]  membrane_q, membrane_d;
  logic [CUR_W-1:0]  held_q, held_d;
  logic [REFR_W-1:0] left_q, left_d;
  logic [VAL_W-1:0]  racc_q, racc_d;
  // Working registers
  logic [VAL_W-1:0]  spike_q;
  logic [CUR_W-1:0]  cur_q;
  logic [HB_W-1:0]   hb_q, hb_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [PROD_W-1:0] prod_q;
  logic [PW_W-1:0]   res_q, res_d;
  logic [PW_W-1:0]   base_q, base_d;
  logic [REFR_W-1:0] n_q, n_d;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_full;
  logic [PROD_W-1:0]        prod_rnd;
  logic [ACC_W-1:0]         rnd_acc;
  logic [ACC_W-1:0]         racc_ext;
  logic [ACC_W-1:0]         floor_ext;
  logic [ACC_W-1:0]         racc_sum;

  // Shared multiplier operand select
  always_comb begin
    unique case (ctrl_i.mul)
      MUL_MEM_DECAY: begin
        mul_a = {{(MA_W-VAL_W){membrane_q[VAL_W-1]}}, membrane_q};
        mul_b = {{(MB_W-DEC_W){1'b0}}, cfg_i.decay};
      end
      MUL_HB_GAIN: begin
        mul_a = {{(MA_W-HB_W){hb_q[HB_W-1]}}, hb_q};
        mul_b = {{(MB_W-GAIN_W){1'b0}}, cfg_i.gain};
      end
      MUL_RES_BASE: begin
        mul_a = {{(MA_W-PW_W){1'b0}}, res_q};
        mul_b = {{(MB_W-PW_W){1'b0}}, base_q};
      end
      MUL_BASE_BASE: begin
        mul_a = {{(MA_W-PW_W){1'b0}}, base_q};
        mul_b = {{(MB_W-PW_W){1'b0}}, base_q};
      end
      MUL_SPIKE_RES: begin
        mul_a = {{(MA_W-VAL_W){spike_q[VAL_W-1]}}, spike_q};
        mul_b = {{(MB_W-PW_W){1'b0}}, res_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_full = mul_a * mul_b;
  end

  // Round registered product to nearest, halves up (floor of x + 1/2)
  assign prod_rnd  = prod_q + RND_HALF;
  assign rnd_acc   = {{(ACC_W-RND_W){prod_rnd[PROD_W-1]}}, prod_rnd[PROD_W-1:FRAC_W]};
  assign racc_ext  = {{(ACC_W-VAL_W){racc_q[VAL_W-1]}}, racc_q};
  assign floor_ext = {{(ACC_W-VAL_W){cfg_i.floor_level[VAL_W-1]}}, cfg_i.floor_level};
  assign racc_sum  = racc_ext + rnd_acc;

  // Accumulator and write-back
  always_comb begin
    acc_d      = acc_q;
    hb_d       = hb_q;
    membrane_d = membrane_q;
    held_d     = held_q;
    left_d     = left_q;
    racc_d     = racc_q;
    res_d      = res_q;
    base_d     = base_q;
    n_d        = n_q;

    unique case (ctrl_i.acc)
      ACC_LOAD_IN: begin
        acc_d = {{(ACC_W-VAL_W){spike_q[VAL_W-1]}}, spike_q};
        hb_d  = {held_q[CUR_W-1], held_q} + {cfg_i.bias[CUR_W-1], cfg_i.bias};
      end
      ACC_ADD_RACC: begin
        // spikes held back during refractoriness join the first free tick
        if (cfg_i.hold) begin
          acc_d  = acc_q + racc_ext;
          racc_d = '0;
        end
      end
      ACC_ADD_PROD: acc_d = acc_q + rnd_acc;
      default: ;
    endcase

    unique case (ctrl_i.wb)
      WB_MEMBRANE: begin
        if ($signed(acc_q) < $signed(floor_ext)) begin
          membrane_d = cfg_i.floor_level;
        end else begin
          membrane_d = sat_val(acc_q);
        end
      end
      WB_PW_INIT: begin
        res_d  = PW_ONE;
        base_d = {{(PW_W-DEC_W){1'b0}}, cfg_i.decay};
        n_d    = left_q;
      end
      WB_RES_COND: begin
        if (n_q[0]) begin
          res_d = prod_rnd[FRAC_W +: PW_W];
        end
      end
      WB_BASE_SHIFT: begin
        base_d = prod_rnd[FRAC_W +: PW_W];
        n_d    = n_q >> 1;
      end
      WB_RACC: racc_d = sat_val(racc_sum);
      WB_DEC:  left_d = left_q - REFR_W'(1);
      WB_FIRE: begin
        held_d = cur_q;
        // threshold test also runs in refractory ticks on the held membrane;
        // on a fire the 8-bit step register is loaded from the refractory limit
        if (fire_o) begin
          left_d     = cfg_i.refr_steps;
          membrane_d = cfg_i.reset_level;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      membrane_q <= '0;
      held_q     <= '0;
      left_q     <= '0;
      racc_q     <= '0;
    end else begin
      membrane_q <= membrane_d;
      held_q     <= held_d;
      left_q     <= left_d;
      racc_q     <= racc_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      spike_q <= spike_i;
      cur_q   <= current_i;
    end
    if (ctrl_i.mul != MUL_NONE) begin
      prod_q <= prod_full;
    end
    acc_q  <= acc_d;
    hb_q   <= hb_d;
    res_q  <= res_d;
    base_q <= base_d;
    n_q    <= n_d;
  end

  assign flags_o.refr  = left_q != '0;
  assign flags_o.hold  = cfg_i.hold;
  assign flags_o.nmore = n_q[REFR_W-1:1] != '0;

  assign fire_o      = $signed(membrane_q) >= $signed(cfg_i.threshold);
  assign potential_o = fire_o ? cfg_i.reset_level : membrane_q;

endmodule

`default_nettype wire

@@ hw/rtl/lif_neuron_delta_synapse_step.sv @@
// Top level of the LIF neuron with delta synapses, one tick per item.
// Depends on lnds_pkg, lnds_cfg, lnds_seq and lnds_dp.
//
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tdata: spike_weight[23:0], current_in[47:24]
//  m_axis    | out       | tdata: potential[23:0]; tuser: fired
//  apb       | in/out    | 8 registers at byte address 4*i, writes when idle
//
// An item runs as a microprogram on one shared 26x21 multiplier after the
// accept cycle; a refractory tick without hold skips the multiplies, and with
// hold the squaring loop runs once per bit of the refractory count (at most 8).
// Reset clears the neuron state and loads the register defaults.
// The final step waits while an earlier result still sits in the output
// register; a new item is taken the cycle after the final step has loaded
// the output register, whether or not that result has been taken yet.
`default_nettype none

module lif_neuron_delta_synapse_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input items
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [47:0]                  s_axis_tdata,  // spike_weight, current_in
  // result items
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [23:0]                  m_axis_tdata,  // potential
  output logic                              m_axis_tuser,  // fired
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lnds_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lnds_pkg::DATA_W-1:0]  pwdata,
  output logic      [lnds_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import lnds_pkg::*;

  cfg_t             cfg;
  ctrl_t            ctrl;
  flags_t           flags;
  logic             busy;
  logic             accept;
  logic             out_free;
  logic             fire;
  logic [VAL_W-1:0] potential;

  logic             out_valid_q;
  logic             out_fired_q;
  logic [VAL_W-1:0] out_pot_q;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  assign out_free      = !out_valid_q || m_axis_tready;

  lnds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lnds_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .flags_i    (flags),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  lnds_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .load_i      (accept),
    .spike_i     (s_axis_tdata[VAL_W-1:0]),
    .current_i   (s_axis_tdata[VAL_W +: CUR_W]),
    .flags_o     (flags),
    .fire_o      (fire),
    .potential_o (potential)
  );

  // Output register: loaded by the final step, cleared when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.wb == WB_FIRE) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.wb == WB_FIRE) begin
      out_fired_q <= fire;
      out_pot_q   <= potential;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pot_q;
  assign m_axis_tuser  = out_fired_q;

endmodule

`default_nettype wire
